FILE: rtl/cau_pkg.sv
`default_nettype none

package cau_pkg;

  // Field and datapath widths
  localparam int FIELD_W    = 32;
  localparam int ACT_W      = 3;
  localparam int PROD_W     = 2 * FIELD_W;      // one exact product
  localparam int SUM_W      = PROD_W + 1;       // sum of two products, signed
  localparam int DIR_W      = FIELD_W + 1;      // add, subtract, negate
  localparam int QD_W       = FIELD_W + 1;      // widest quotient kept
  localparam int DIV_W      = PROD_W + QD_W;    // scaled dividend and shifted divisor
  localparam int SQRT_STEPS = PROD_W / 2;       // one root bit per step

  // Defaults for the top-level parameters
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD  = 3'd0,
    ACT_SUB  = 3'd1,
    ACT_MUL  = 3'd2,
    ACT_DIV  = 3'd3,
    ACT_CONJ = 3'd4,
    ACT_NEG  = 3'd5,
    ACT_MAG2 = 3'd6,
    ACT_MAG  = 3'd7
  } action_t;

  // How the result of a transaction is finished
  typedef enum logic [1:0] {
    KIND_DIRECT = 2'd0,
    KIND_DIV    = 2'd1,
    KIND_SQRT   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [FIELD_W-1:0] value;
    logic               sat;
  } sat_res_t;

  // Payload of the iterative divide / root stages
  typedef struct packed {
    kind_t                        kind;
    logic                         fir;
    logic                         dz;
    logic [FIELD_W-1:0]           fin_re;
    logic [FIELD_W-1:0]           fin_im;
    logic                         fin_sat;
    logic [1:0]                   neg;
    logic [1:0]                   ovf;
    logic [PROD_W-1:0]            den;
    logic [1:0][PROD_W-1:0]       rem;
    logic [1:0][QD_W-1:0]         qd;
    logic [PROD_W-1:0]            sq_v;
    logic [PROD_W-1:0]            sq_res;
  } iter_t;

endpackage

`default_nettype wire

FILE: rtl/cau_in_if.sv
`default_nettype none

interface cau_in_if import cau_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [ACT_W-1:0]          action;
  logic signed [FIELD_W-1:0] first_real;
  logic signed [FIELD_W-1:0] first_imag;
  logic signed [FIELD_W-1:0] second_real;
  logic signed [FIELD_W-1:0] second_imag;

  modport source (
    output valid, action, first_real, first_imag, second_real, second_imag,
    input  ready
  );
  modport sink (
    input  valid, action, first_real, first_imag, second_real, second_imag,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/cau_out_if.sv
`default_nettype none

interface cau_out_if import cau_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] result_real;
  logic signed [FIELD_W-1:0] result_imag;
  logic                      div_by_zero;
  logic                      saturated;
  logic                      first_is_real;

  modport source (
    output valid, result_real, result_imag, div_by_zero, saturated, first_is_real,
    input  ready
  );
  modport sink (
    input  valid, result_real, result_imag, div_by_zero, saturated, first_is_real,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/cau_step_stage.sv
`default_nettype none

// One pipeline stage: a restoring divide step on both lanes and one root bit
module cau_step_stage import cau_pkg::*; #(
  parameter int STEP = 0,
  parameter int QW   = QD_W
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  up_valid,
  output logic  up_ready,
  input  iter_t up_data,
  output logic  down_valid,
  input  logic  down_ready,
  output iter_t down_data
);

  localparam bit DIV_ON   = STEP < QW;
  localparam bit SQ_ON    = STEP < SQRT_STEPS;
  localparam int SQ_SHIFT = SQ_ON ? (2 * SQRT_STEPS - 2 - 2 * STEP) : 0;
  localparam logic [PROD_W-1:0] SQ_BIT = PROD_W'(1) << SQ_SHIFT;

  logic               v_r;
  logic               en;
  iter_t              data_r;
  iter_t              data_nxt;
  logic [PROD_W:0]    rsh  [2];
  logic [PROD_W:0]    diff [2];
  logic [1:0]         ge;
  logic [PROD_W-1:0]  sq_t;
  logic               sq_ge;

  assign en       = !v_r || down_ready;
  assign up_ready = en;

  // divide and root step
  always_comb begin
    data_nxt = up_data;
    for (int l = 0; l < 2; l++) begin
      rsh[l]  = {up_data.rem[l], up_data.qd[l][QW-1]};
      diff[l] = rsh[l] - {1'b0, up_data.den};
      ge[l]   = rsh[l] >= {1'b0, up_data.den};
      if (DIV_ON) begin
        data_nxt.rem[l] = ge[l] ? diff[l][PROD_W-1:0] : rsh[l][PROD_W-1:0];
        data_nxt.qd[l]  = {up_data.qd[l][QD_W-2:0], ge[l]};
      end
    end
    sq_t  = up_data.sq_res + SQ_BIT;
    sq_ge = up_data.sq_v >= sq_t;
    if (SQ_ON) begin
      if (sq_ge) begin
        data_nxt.sq_v   = up_data.sq_v - sq_t;
        data_nxt.sq_res = (up_data.sq_res >> 1) + SQ_BIT;
      end else begin
        data_nxt.sq_res = up_data.sq_res >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign down_valid = v_r;
  assign down_data  = data_r;

endmodule

`default_nettype wire

FILE: rtl/complex_arithmetic_unit_core.sv
// Throughput: one transaction per cycle, every action, unless stalled; the figure is set
// by the restoring divider, one quotient bit per stage, and the root, one bit per stage.
// Each stage carries its own valid bit; a stall holds only the stages behind it.
// Reset (synchronous, rst_n low) clears the valid bits; data registers are not reset.
`default_nettype none

module complex_arithmetic_unit_core import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  cau_in_if.sink    in_chan,
  cau_out_if.source out_chan
);

  localparam int SAT_W = (DATA_WIDTH > FIELD_W) ? FIELD_W :
                         ((DATA_WIDTH < 2) ? 2 : DATA_WIDTH);
  localparam int QW    = SAT_W + 1;
  localparam int ITERS = (QW > SQRT_STEPS) ? QW : SQRT_STEPS;
  localparam logic signed [SUM_W-1:0] SAT_HI =
    $signed((SUM_W'(1) << (SAT_W - 1)) - SUM_W'(1));
  localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic [FIELD_W-1:0] HI_F = SAT_HI[FIELD_W-1:0];
  localparam logic [FIELD_W-1:0] LO_F = SAT_LO[FIELD_W-1:0];

  typedef struct packed {
    kind_t                  kind;
    logic                   fir;
    logic                   dz;
    logic [FIELD_W-1:0]     fin_re;
    logic [FIELD_W-1:0]     fin_im;
    logic                   fin_sat;
    logic [1:0]             neg;
    logic [1:0][PROD_W-1:0] mag;
    logic [PROD_W-1:0]      den;
    logic [PROD_W-1:0]      sq_v;
  } prep_t;

  function automatic sat_res_t saturate(input logic signed [SUM_W-1:0] x);
    sat_res_t r;
    if (x > SAT_HI) begin
      r.value = HI_F;
      r.sat   = 1'b1;
    end else if (x < SAT_LO) begin
      r.value = LO_F;
      r.sat   = 1'b1;
    end else begin
      r.value = x[FIELD_W-1:0];
      r.sat   = 1'b0;
    end
    return r;
  endfunction

  // Handshake chain
  logic en_a, en_b, en_c, en_d, en_o;
  logic v_a_r, v_b_r, v_c_r, v_d_r, v_o_r;
  logic  [ITERS:0] it_valid;
  logic  [ITERS:0] it_ready;
  iter_t           it_data [ITERS+1];

  assign en_o          = !v_o_r || out_chan.ready;
  assign it_ready[ITERS] = en_o;
  assign en_d          = !v_d_r || it_ready[0];
  assign en_c          = !v_c_r || en_d;
  assign en_b          = !v_b_r || en_c;
  assign en_a          = !v_a_r || en_b;
  assign in_chan.ready = en_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
      v_o_r <= 1'b0;
    end else begin
      if (en_a) v_a_r <= in_chan.valid;
      if (en_b) v_b_r <= v_a_r;
      if (en_c) v_c_r <= v_b_r;
      if (en_d) v_d_r <= v_c_r;
      if (en_o) v_o_r <= it_valid[ITERS];
    end
  end

  // Stage A: products and the plain add / subtract / conjugate / negate results
  logic signed [FIELD_W-1:0] fa, fb, fc, fd, m0y, m1y;
  action_t                   act_in;
  logic signed [PROD_W-1:0]  p_nxt [6];
  logic signed [DIR_W-1:0]   dre_nxt, dim_nxt;
  action_t                   act_a_r;
  logic signed [PROD_W-1:0]  p_a_r [6];
  logic signed [DIR_W-1:0]   dre_a_r, dim_a_r;
  logic                      fir_a_r;

  assign fa     = in_chan.first_real;
  assign fb     = in_chan.first_imag;
  assign fc     = in_chan.second_real;
  assign fd     = in_chan.second_imag;
  assign act_in = action_t'(in_chan.action);

  always_comb begin
    m0y = fc;
    m1y = fd;
    if (act_in == ACT_MAG2 || act_in == ACT_MAG) begin
      m0y = fa;
      m1y = fb;
    end
    p_nxt[0] = PROD_W'(fa) * PROD_W'(m0y);
    p_nxt[1] = PROD_W'(fb) * PROD_W'(m1y);
    p_nxt[2] = PROD_W'(fa) * PROD_W'(fd);
    p_nxt[3] = PROD_W'(fb) * PROD_W'(fc);
    p_nxt[4] = PROD_W'(fc) * PROD_W'(fc);
    p_nxt[5] = PROD_W'(fd) * PROD_W'(fd);
    case (act_in)
      ACT_ADD: begin
        dre_nxt = DIR_W'(fa) + DIR_W'(fc);
        dim_nxt = DIR_W'(fb) + DIR_W'(fd);
      end
      ACT_SUB: begin
        dre_nxt = DIR_W'(fa) - DIR_W'(fc);
        dim_nxt = DIR_W'(fb) - DIR_W'(fd);
      end
      ACT_CONJ: begin
        dre_nxt = DIR_W'(fa);
        dim_nxt = -DIR_W'(fb);
      end
      ACT_NEG: begin
        dre_nxt = -DIR_W'(fa);
        dim_nxt = -DIR_W'(fb);
      end
      default: begin
        dre_nxt = '0;
        dim_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en_a && in_chan.valid) begin
      act_a_r <= act_in;
      p_a_r   <= p_nxt;
      dre_a_r <= dre_nxt;
      dim_a_r <= dim_nxt;
      fir_a_r <= (fb == '0);
    end
  end

  // Stage B: sums of products and the divisor
  logic signed [SUM_W-1:0]  pr_nxt, pi_nxt;
  logic [PROD_W-1:0]        den_nxt;
  action_t                  act_b_r;
  logic signed [SUM_W-1:0]  pr_b_r, pi_b_r;
  logic [PROD_W-1:0]        den_b_r;
  logic signed [DIR_W-1:0]  dre_b_r, dim_b_r;
  logic                     fir_b_r;

  always_comb begin
    case (act_a_r) inside
      ACT_MUL: begin
        pr_nxt = SUM_W'(p_a_r[0]) - SUM_W'(p_a_r[1]);
        pi_nxt = SUM_W'(p_a_r[2]) + SUM_W'(p_a_r[3]);
      end
      ACT_DIV: begin
        pr_nxt = SUM_W'(p_a_r[0]) + SUM_W'(p_a_r[1]);
        pi_nxt = SUM_W'(p_a_r[3]) - SUM_W'(p_a_r[2]);
      end
      ACT_MAG2, ACT_MAG: begin
        pr_nxt = SUM_W'(p_a_r[0]) + SUM_W'(p_a_r[1]);
        pi_nxt = '0;
      end
      default: begin
        pr_nxt = '0;
        pi_nxt = '0;
      end
    endcase
    den_nxt = $unsigned(p_a_r[4]) + $unsigned(p_a_r[5]);
  end

  always_ff @(posedge clk) begin
    if (en_b && v_a_r) begin
      act_b_r <= act_a_r;
      pr_b_r  <= pr_nxt;
      pi_b_r  <= pi_nxt;
      den_b_r <= den_nxt;
      dre_b_r <= dre_a_r;
      dim_b_r <= dim_a_r;
      fir_b_r <= fir_a_r;
    end
  end

  // Stage C: rescale and clamp the direct results, magnitudes for the divider
  sat_res_t sr, si, mr, mi;
  prep_t    c_nxt, c_r;

  always_comb begin
    sr = saturate(SUM_W'(dre_b_r));
    si = saturate(SUM_W'(dim_b_r));
    mr = saturate(pr_b_r >>> FRAC_BITS);
    mi = saturate(pi_b_r >>> FRAC_BITS);
    c_nxt.fir    = fir_b_r;
    c_nxt.dz     = (den_b_r == '0);
    c_nxt.neg    = {pi_b_r[SUM_W-1], pr_b_r[SUM_W-1]};
    c_nxt.mag[0] = PROD_W'(pr_b_r[SUM_W-1] ? -pr_b_r : pr_b_r);
    c_nxt.mag[1] = PROD_W'(pi_b_r[SUM_W-1] ? -pi_b_r : pi_b_r);
    c_nxt.den    = den_b_r;
    c_nxt.sq_v   = pr_b_r[PROD_W-1:0];
    c_nxt.kind   = KIND_DIRECT;
    c_nxt.fin_re = '0;
    c_nxt.fin_im = '0;
    c_nxt.fin_sat = 1'b0;
    case (act_b_r) inside
      ACT_ADD, ACT_SUB, ACT_CONJ, ACT_NEG: begin
        c_nxt.fin_re  = sr.value;
        c_nxt.fin_im  = si.value;
        c_nxt.fin_sat = sr.sat | si.sat;
      end
      ACT_MUL: begin
        c_nxt.fin_re  = mr.value;
        c_nxt.fin_im  = mi.value;
        c_nxt.fin_sat = mr.sat | mi.sat;
      end
      ACT_MAG2: begin
        c_nxt.fin_re  = mr.value;
        c_nxt.fin_sat = mr.sat;
      end
      ACT_DIV: c_nxt.kind = KIND_DIV;
      ACT_MAG: c_nxt.kind = KIND_SQRT;
      default: c_nxt.kind = KIND_DIRECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en_c && v_b_r) begin
      c_r <= c_nxt;
    end
  end

  // Stage D: scale the dividends, detect quotient overflow, seed the divider
  logic [DIV_W-1:0] dsh [2];
  logic [DIV_W-1:0] dcmp;
  iter_t            d_nxt, d_r;

  always_comb begin
    dcmp          = DIV_W'(c_r.den) << QW;
    d_nxt.kind    = c_r.kind;
    d_nxt.fir     = c_r.fir;
    d_nxt.dz      = c_r.dz;
    d_nxt.fin_re  = c_r.fin_re;
    d_nxt.fin_im  = c_r.fin_im;
    d_nxt.fin_sat = c_r.fin_sat;
    d_nxt.neg     = c_r.neg;
    d_nxt.den     = c_r.den;
    d_nxt.sq_v    = c_r.sq_v;
    d_nxt.sq_res  = '0;
    for (int l = 0; l < 2; l++) begin
      dsh[l]        = DIV_W'(c_r.mag[l]) << FRAC_BITS;
      d_nxt.ovf[l]  = dsh[l] >= dcmp;
      d_nxt.rem[l]  = PROD_W'(dsh[l] >> QW);
      d_nxt.qd[l]   = dsh[l][QD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en_d && v_c_r) begin
      d_r <= d_nxt;
    end
  end

  assign it_valid[0] = v_d_r;
  assign it_data[0]  = d_r;

  // Divider and root pipeline
  for (genvar k = 0; k < ITERS; k++) begin : g_step
    cau_step_stage #(
      .STEP (k),
      .QW   (QW)
    ) u_step (
      .clk        (clk),
      .rst_n      (rst_n),
      .up_valid   (it_valid[k]),
      .up_ready   (it_ready[k]),
      .up_data    (it_data[k]),
      .down_valid (it_valid[k+1]),
      .down_ready (it_ready[k+1]),
      .down_data  (it_data[k+1])
    );
  end

  // Output stage: sign and clamp the quotients and the root, pick the result
  iter_t                   t;
  logic signed [SUM_W-1:0] qv [2];
  sat_res_t                dq [2];
  sat_res_t                sq;
  logic [FIELD_W-1:0]      re_nxt, im_nxt;
  logic                    dz_nxt, sat_nxt;
  logic [FIELD_W-1:0]      o_re_r, o_im_r;
  logic                    o_dz_r, o_sat_r, o_fir_r;

  always_comb begin
    t = it_data[ITERS];
    for (int l = 0; l < 2; l++) begin
      qv[l] = $signed(SUM_W'(t.qd[l][QW-1:0]));
      if (t.neg[l]) begin
        qv[l] = -qv[l];
      end
      if (t.ovf[l]) begin
        dq[l].value = t.neg[l] ? LO_F : HI_F;
        dq[l].sat   = 1'b1;
      end else begin
        dq[l] = saturate(qv[l]);
      end
    end
    sq = saturate($signed(SUM_W'(t.sq_res)));
    dz_nxt = 1'b0;
    case (t.kind)
      KIND_DIV: begin
        if (t.dz) begin
          re_nxt  = '0;
          im_nxt  = '0;
          sat_nxt = 1'b0;
          dz_nxt  = 1'b1;
        end else begin
          re_nxt  = dq[0].value;
          im_nxt  = dq[1].value;
          sat_nxt = dq[0].sat | dq[1].sat;
        end
      end
      KIND_SQRT: begin
        re_nxt  = sq.value;
        im_nxt  = '0;
        sat_nxt = sq.sat;
      end
      default: begin
        re_nxt  = t.fin_re;
        im_nxt  = t.fin_im;
        sat_nxt = t.fin_sat;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en_o && it_valid[ITERS]) begin
      o_re_r  <= re_nxt;
      o_im_r  <= im_nxt;
      o_dz_r  <= dz_nxt;
      o_sat_r <= sat_nxt;
      o_fir_r <= t.fir;
    end
  end

  assign out_chan.valid         = v_o_r;
  assign out_chan.result_real   = o_re_r;
  assign out_chan.result_imag   = o_im_r;
  assign out_chan.div_by_zero   = o_dz_r;
  assign out_chan.saturated     = o_sat_r;
  assign out_chan.first_is_real = o_fir_r;

  // Input is held off only when every stage is full and the output is stalled
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (out_chan.valid && !out_chan.ready))
    else $error("input stalled while the pipeline can still move");

  // Division by zero gives clean zeros and no clamp
  a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.div_by_zero) |->
      (!out_chan.saturated && out_chan.result_real == '0 && out_chan.result_imag == '0))
    else $error("division by zero result not zero");

  // A clamped transaction carries a bound in at least one part
  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.saturated) |->
      (out_chan.result_real == HI_F || out_chan.result_real == LO_F ||
       out_chan.result_imag == HI_F || out_chan.result_imag == LO_F))
    else $error("saturated flag without a clamped part");

endmodule

`default_nettype wire

FILE: sim/tb_complex_arithmetic_unit_core.sv
`default_nettype none

module tb_complex_arithmetic_unit_core;
  timeunit 1ns;
  timeprecision 1ps;
  import cau_pkg::*;

  localparam int LATENCY   = 38;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 530;

  typedef struct {
    logic [ACT_W-1:0]   action;
    logic [FIELD_W-1:0] a, b, c, d;
  } cmplx_op_t;

  typedef struct {
    logic [FIELD_W-1:0] re, im;
    logic               dz, sat, fir;
  } cmplx_res_t;

  // Sign plus magnitude, wide enough for every exact intermediate
  typedef struct {
    bit          neg;
    logic [63:0] mag;
  } sm_t;

  int errors = 0;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
  endtask

  // Predictor helpers
  function automatic logic [63:0] mag_of(longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  function automatic sm_t sm_mul(longint x, longint y);
    sm_t r;
    r.mag = mag_of(x) * mag_of(y);
    r.neg = ((x < 0) != (y < 0)) && r.mag != 0;
    return r;
  endfunction

  function automatic sm_t sm_from(longint x);
    sm_t r;
    r.mag = mag_of(x);
    r.neg = x < 0;
    return r;
  endfunction

  function automatic sm_t sm_neg(sm_t p);
    p.neg = !p.neg && p.mag != 0;
    return p;
  endfunction

  function automatic sm_t sm_add(sm_t p, sm_t q);
    sm_t r;
    if (p.neg == q.neg) begin
      r.mag = p.mag + q.mag; r.neg = p.neg;
    end else if (p.mag >= q.mag) begin
      r.mag = p.mag - q.mag; r.neg = p.neg;
    end else begin
      r.mag = q.mag - p.mag; r.neg = q.neg;
    end
    if (r.mag == 0) r.neg = 0;
    return r;
  endfunction

  function automatic sm_t sm_rescale(sm_t p);
    if (p.neg) p.mag = (p.mag + 64'hFFFF) >> 16;
    else       p.mag = p.mag >> 16;
    if (p.mag == 0) p.neg = 0;
    return p;
  endfunction

  function automatic logic [FIELD_W-1:0] clamp(sm_t p, inout logic sat);
    logic [63:0] lim;
    lim = 64'h7FFF_FFFF;
    if (!p.neg) begin
      if (p.mag > lim) begin sat = 1; return 32'h7FFF_FFFF; end
      return p.mag[31:0];
    end
    if (p.mag > lim + 1) begin sat = 1; return 32'h8000_0000; end
    return 32'(-p.mag);
  endfunction

  function automatic sm_t sm_div(sm_t num, logic [63:0] den);
    sm_t r;
    logic [63:0] q, rem;
    q = num.mag / den;
    rem = num.mag % den;
    for (int i = 0; i < 16; i++) begin
      if (q >= (64'd1 << 40)) break;
      q = q << 1;
      if (rem >= den - rem) begin
        rem = rem - (den - rem);
        q[0] = 1'b1;
      end else begin
        rem = rem << 1;
      end
    end
    r.mag = q;
    r.neg = num.neg && q != 0;
    return r;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic cmplx_res_t predict_cmplx(cmplx_op_t op);
    cmplx_res_t r;
    longint a, b, c, d;
    sm_t pr, pi, m, sq0, sq1;
    logic [63:0] den;
    logic sat;
    a = longint'($signed(op.a)); b = longint'($signed(op.b));
    c = longint'($signed(op.c)); d = longint'($signed(op.d));
    sat = 0;
    r.re = 0; r.im = 0; r.dz = 0;
    case (action_t'(op.action))
      ACT_ADD: begin
        r.re = clamp(sm_from(a + c), sat); r.im = clamp(sm_from(b + d), sat);
      end
      ACT_SUB: begin
        r.re = clamp(sm_from(a - c), sat); r.im = clamp(sm_from(b - d), sat);
      end
      ACT_MUL: begin
        pr = sm_add(sm_mul(a, c), sm_neg(sm_mul(b, d)));
        pi = sm_add(sm_mul(a, d), sm_mul(b, c));
        r.re = clamp(sm_rescale(pr), sat); r.im = clamp(sm_rescale(pi), sat);
      end
      ACT_DIV: begin
        sq0 = sm_mul(c, c);
        sq1 = sm_mul(d, d);
        den = sq0.mag + sq1.mag;
        if (den == 0) begin
          r.dz = 1;
        end else begin
          pr = sm_add(sm_mul(a, c), sm_mul(b, d));
          pi = sm_add(sm_mul(b, c), sm_neg(sm_mul(a, d)));
          r.re = clamp(sm_div(pr, den), sat); r.im = clamp(sm_div(pi, den), sat);
        end
      end
      ACT_CONJ: begin
        r.re = clamp(sm_from(a), sat); r.im = clamp(sm_from(-b), sat);
      end
      ACT_NEG: begin
        r.re = clamp(sm_from(-a), sat); r.im = clamp(sm_from(-b), sat);
      end
      ACT_MAG2: begin
        pr = sm_add(sm_mul(a, a), sm_mul(b, b));
        r.re = clamp(sm_rescale(pr), sat);
      end
      default: begin
        sq0 = sm_mul(a, a);
        sq1 = sm_mul(b, b);
        m.neg = 0;
        m.mag = floor_sqrt(sq0.mag + sq1.mag);
        r.re = clamp(m, sat);
      end
    endcase
    r.sat = sat;
    r.fir = (b == 0);
    return r;
  endfunction

  // Scoreboard: expected results in order of acceptance
  class cmplx_scoreboard;
    cmplx_res_t pending[$];

    function void note_input(cmplx_op_t op);
      pending.push_back(predict_cmplx(op));
    endfunction

    task check_result(cmplx_res_t got);
      cmplx_res_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", 64'(got.re), 64'd0);
        return;
      end
      want = pending.pop_front();
      if (got.re !== want.re)
        report_mismatch("result_real", 64'(got.re), 64'(want.re));
      if (got.im !== want.im)
        report_mismatch("result_imag", 64'(got.im), 64'(want.im));
      if (got.dz !== want.dz)
        report_mismatch("div_by_zero", 64'(got.dz), 64'(want.dz));
      if (got.sat !== want.sat)
        report_mismatch("saturated", 64'(got.sat), 64'(want.sat));
      if (got.fir !== want.fir)
        report_mismatch("first_is_real", 64'(got.fir), 64'(want.fir));
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  always #6 clk = ~clk;

  cau_in_if  in_chan();
  cau_out_if out_chan();

  complex_arithmetic_unit_core dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source)
  );

  cmplx_scoreboard sb = new();
  bit hold_off = 0;     // long receiver stall requested by the sender
  bit rand_stall = 1;

  initial begin
    in_chan.valid = 0;
    in_chan.action = 0;
    in_chan.first_real = 0; in_chan.first_imag = 0;
    in_chan.second_real = 0; in_chan.second_imag = 0;
    out_chan.ready = 0;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Monitor: note inputs and check results at each edge
  always @(posedge clk) begin
    cmplx_op_t op;
    cmplx_res_t res;
    if (rst_n && in_chan.valid && in_chan.ready) begin
      op.action = in_chan.action;
      op.a = in_chan.first_real; op.b = in_chan.first_imag;
      op.c = in_chan.second_real; op.d = in_chan.second_imag;
      sb.note_input(op);
    end
    if (rst_n && out_chan.valid && out_chan.ready) begin
      res.re = out_chan.result_real; res.im = out_chan.result_imag;
      res.dz = out_chan.div_by_zero; res.sat = out_chan.saturated;
      res.fir = out_chan.first_is_real;
      sb.check_result(res);
    end
  end

  // Receiver: random ready, plus one long hold-off counted here
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_chan.ready <= 0;
        repeat (200) @(posedge clk);
        hold_off = 0;
      end else if (rand_stall && (n = gap_len()) > 0) begin
        out_chan.ready <= 0;
        repeat (n) @(posedge clk);
      end else begin
        out_chan.ready <= 1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Watchdog on cycles without any transaction
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        idle = 0;
      else
        idle++;
      if (idle >= WDOG_MAX) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_op(cmplx_op_t op, bit gaps);
    int n;
    n = gaps ? gap_len() : 0;
    if (n > 0) begin
      in_chan.valid <= 0;
      repeat (n) @(posedge clk);
    end
    in_chan.valid <= 1;
    in_chan.action <= op.action;
    in_chan.first_real <= op.a; in_chan.first_imag <= op.b;
    in_chan.second_real <= op.c; in_chan.second_imag <= op.d;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  task automatic send_fields(action_t act, logic [31:0] a, logic [31:0] b,
                             logic [31:0] c, logic [31:0] d);
    cmplx_op_t op;
    op.action = act; op.a = a; op.b = b; op.c = c; op.d = d;
    send_op(op, 1);
  endtask

  function automatic logic [31:0] rand_operand();
    int p;
    p = $urandom_range(0, 9);
    case (p)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 0;
      3, 4: return 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF);
      default: return $urandom();
    endcase
  endfunction

  task automatic idle_until_drained();
    in_chan.valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    cmplx_op_t op;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes, each action, division by zero, negation of minimum
    for (int k = 0; k < 8; k++)
      send_fields(action_t'(k), 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_fields(ACT_DIV, 32'h0001_0000, 32'h0002_0000, 0, 0);
    send_fields(ACT_DIV, 32'h8000_0000, 32'h8000_0000, 1, 0);
    send_fields(ACT_DIV, 32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'hFFFF_0000);
    send_fields(ACT_NEG, 32'h8000_0000, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_fields(ACT_CONJ, 0, 32'h8000_0000, 0, 0);
    send_fields(ACT_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_fields(ACT_MUL, 32'hFFFF_FFFF, 0, 1, 0);
    send_fields(ACT_MAG, 32'h8000_0000, 32'h8000_0000, 0, 0);
    send_fields(ACT_MAG2, 32'h0001_0000, 32'hFFFF_0000, 0, 0);
    send_fields(ACT_ADD, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_fields(ACT_SUB, 32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_fields(ACT_MAG, 0, 0, 0, 0);

    // Sender pauses until everything has come back
    idle_until_drained();

    // Back-to-back burst against a long receiver stall
    hold_off = 1;
    for (int i = 0; i < 120; i++) begin
      op.action = ACT_W'($urandom_range(0, 7));
      op.a = rand_operand(); op.b = rand_operand();
      op.c = rand_operand(); op.d = rand_operand();
      send_op(op, 0);
    end

    // Random transactions with gaps
    for (int i = 0; i < N_RANDOM - 120; i++) begin
      op.action = ACT_W'($urandom_range(0, 7));
      op.a = rand_operand(); op.b = rand_operand();
      op.c = rand_operand(); op.d = rand_operand();
      if ($urandom_range(0, 9) == 0) begin op.c = 0; op.d = 0; end
      send_op(op, 1);
    end

    idle_until_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && sb.pending.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
